// ----- design/lrs_pkg.sv -----
package lrs_pkg;

	localparam int MAX_POINTS = 128;
	localparam int FRAC_BITS  = 16;
	localparam int ADDR_W     = $clog2(MAX_POINTS);
	localparam int CNT_W      = $clog2(MAX_POINTS + 1);
	localparam int ACC_W      = 48;
	localparam int R2_W       = FRAC_BITS + 1;

	typedef enum logic [2:0] {
		STAT_OK   = 3'd0,
		STAT_FEW  = 3'd1,
		STAT_NO_X = 3'd2,
		STAT_NO_Y = 3'd3,
		STAT_OVF  = 3'd4
	} status_t;

	typedef enum logic [4:0] {
		S_LOAD,
		S_CHECK,
		S_MEAN_X,
		S_MEAN_Y,
		S_PASS,
		S_SLOPE,
		S_PROD,
		S_SSR_MUL,
		S_SSR_DIV,
		S_R2,
		S_RHO,
		S_QV,
		S_SE,
		S_SBQ,
		S_SB,
		S_TV,
		S_DONE
	} step_t;

	typedef struct packed {
		step_t step;
		logic  start;
		logic  accept;
		logic  clear_sums;
		logic  load_out;
		logic  clear_set;
	} cmd_t;

	typedef struct packed {
		logic unit_done;
		logic pass_done;
		logic pre_err;
		logic spread_err;
	} sts_t;

	// saturate a sign and magnitude pair to signed 32 bits
	function automatic logic signed [31:0] sat32(input logic neg, input logic [63:0] mag);
		logic signed [31:0] r;
		if (neg) begin
			if (mag > 64'h0000_0000_8000_0000) r = 32'sh8000_0000;
			else r = $signed(~mag[31:0] + 32'd1);
		end else begin
			if (mag > 64'h0000_0000_7FFF_FFFF) r = 32'sh7FFF_FFFF;
			else r = $signed(mag[31:0]);
		end
		return r;
	endfunction

endpackage

// ----- design/lrs_if.sv -----
interface lrs_in_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] x_value;
	logic signed [31:0] y_value;
	logic               last_point;

	modport source(output valid, output x_value, output y_value, output last_point,
		input ready);
	modport sink(input valid, input x_value, input y_value, input last_point,
		output ready);
endinterface

interface lrs_out_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] intercept;
	logic signed [31:0] slope;
	logic signed [31:0] x_mean;
	logic signed [31:0] y_mean;
	logic [16:0]        r_squared;
	logic signed [17:0] correlation;
	logic [30:0]        std_error;
	logic [30:0]        slope_std_error;
	logic signed [31:0] t_value;
	logic [2:0]         status;

	modport source(output valid, output intercept, output slope, output x_mean,
		output y_mean, output r_squared, output correlation, output std_error,
		output slope_std_error, output t_value, output status, input ready);
	modport sink(input valid, input intercept, input slope, input x_mean,
		input y_mean, input r_squared, input correlation, input std_error,
		input slope_std_error, input t_value, input status, output ready);
endinterface

// ----- design/lrs_div.sv -----
module lrs_div (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  logic [127:0] num,
	input  logic [63:0]  den,
	output logic [63:0]  quo,
	output logic         done
);

	logic         busy_q;
	logic         done_q;
	logic [6:0]   cnt_q;
	logic         sat_q;
	logic [63:0]  rem_q;
	logic [127:0] num_q;
	logic [63:0]  den_q;
	logic [63:0]  quo_q;
	logic [64:0]  trial;
	logic         ge;
	logic [64:0]  nrem;

	// restoring division, one quotient bit a cycle
	always_comb begin
		trial = {rem_q, num_q[127]};
		ge    = trial >= {1'b0, den_q};
		nrem  = ge ? trial - {1'b0, den_q} : trial;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			sat_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
				sat_q  <= 1'b0;
			end else if (busy_q) begin
				sat_q <= sat_q | quo_q[63];
				cnt_q <= cnt_q + 7'd1;
				if (cnt_q == 7'd127) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// the remainder stays below the divisor, so bit 64 of nrem is always clear
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			num_q <= num;
			den_q <= den;
			quo_q <= '0;
		end else if (busy_q) begin
			rem_q <= nrem[63:0];
			num_q <= {num_q[126:0], 1'b0};
			quo_q <= {quo_q[62:0], ge};
		end
	end

	assign quo  = sat_q ? '1 : quo_q;
	assign done = done_q;

endmodule

// ----- design/lrs_sqrt.sv -----
module lrs_sqrt (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  logic [127:0] val,
	output logic [63:0]  root,
	output logic         done
);

	logic         busy_q;
	logic         done_q;
	logic [5:0]   cnt_q;
	logic [127:0] val_q;
	logic [63:0]  root_q;
	logic [65:0]  rem_q;
	logic [67:0]  trem;
	logic [67:0]  trial;
	logic         ge;

	// digit-by-digit root, two radicand bits a cycle
	always_comb begin
		trem  = {rem_q, val_q[127:126]};
		trial = {2'b00, root_q, 2'b01};
		ge    = trem >= trial;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == 6'd63) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// remainder never exceeds twice the partial root, so 66 bits hold it
	always_ff @(posedge clk) begin
		if (start) begin
			val_q  <= val;
			root_q <= '0;
			rem_q  <= '0;
		end else if (busy_q) begin
			val_q  <= {val_q[125:0], 2'b00};
			rem_q  <= ge ? 66'(trem - trial) : trem[65:0];
			root_q <= {root_q[62:0], ge};
		end
	end

	assign root = root_q;
	assign done = done_q;

endmodule

// ----- design/lrs_mul.sv -----
module lrs_mul (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  logic [63:0]  a,
	input  logic [63:0]  b,
	output logic [127:0] prod,
	output logic         done
);

	logic         busy_q;
	logic         done_q;
	logic [1:0]   step_q;
	logic [63:0]  a_q;
	logic [63:0]  b_q;
	logic [127:0] acc_q;
	logic [31:0]  ha;
	logic [31:0]  hb;
	logic [63:0]  pp;
	logic [127:0] pp_sh;

	// one 32x32 partial product a cycle
	always_comb begin
		ha = step_q[1] ? a_q[63:32] : a_q[31:0];
		hb = step_q[0] ? b_q[63:32] : b_q[31:0];
		pp = ha * hb;
		case (step_q)
			2'd0:    pp_sh = {64'd0, pp};
			2'd3:    pp_sh = {pp, 64'd0};
			default: pp_sh = {32'd0, pp, 32'd0};
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + 2'd1;
				if (step_q == 2'd3) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q   <= a;
			b_q   <= b;
			acc_q <= '0;
		end else if (busy_q) begin
			acc_q <= acc_q + pp_sh;
		end
	end

	assign prod = acc_q;
	assign done = done_q;

endmodule

// ----- design/lrs_dp.sv -----
module lrs_dp (
	input  logic               clk,
	input  logic               arst_n,
	input  lrs_pkg::cmd_t      cmd,
	output lrs_pkg::sts_t      sts,
	input  logic signed [31:0] x_value,
	input  logic signed [31:0] y_value,
	output logic signed [31:0] intercept,
	output logic signed [31:0] slope,
	output logic signed [31:0] x_mean,
	output logic signed [31:0] y_mean,
	output logic [16:0]        r_squared,
	output logic signed [17:0] correlation,
	output logic [30:0]        std_error,
	output logic [30:0]        slope_std_error,
	output logic signed [31:0] t_value,
	output logic [2:0]         status
);

	localparam logic [lrs_pkg::CNT_W-1:0] FULL_CNT = lrs_pkg::CNT_W'(lrs_pkg::MAX_POINTS);
	localparam logic [63:0] ONE_Q   = 64'd1 << lrs_pkg::FRAC_BITS;
	localparam logic [63:0] POS_MAX = 64'h0000_0000_7FFF_FFFF;

	// sample store
	logic signed [31:0] xs_mem [lrs_pkg::MAX_POINTS];
	logic signed [31:0] ys_mem [lrs_pkg::MAX_POINTS];

	logic [lrs_pkg::CNT_W-1:0]        count_q;
	logic                             ovf_q;
	logic signed [lrs_pkg::ACC_W-1:0] accx_q;
	logic signed [lrs_pkg::ACC_W-1:0] accy_q;
	logic                             full;

	// second pass
	logic                      pass_act_q;
	logic                      pass_done_q;
	logic [lrs_pkg::CNT_W-1:0] idx_q;
	logic                      issue;
	logic                      v_s1, v_s2, v_s3;
	logic signed [31:0]        x_s1, y_s1;
	logic [31:0]               adx_s2, ady_s2;
	logic                      neg_s2;
	logic [63:0]               pxx_s3, pyy_s3, pxy_s3;
	logic                      neg_s3;
	logic signed [32:0]        dx, dy;
	logic [63:0]               sxx_q, syy_q;
	logic signed [63:0]        sxy_q;

	// fit results
	logic signed [31:0]        xm_q, ym_q, slope_q, icpt_q, t_q;
	logic [127:0]              wide_q;
	logic [63:0]               ssr_q, sse_q, q_q, sbq_q;
	logic [lrs_pkg::R2_W-1:0]  r2_q, rho_q;
	logic [30:0]               se_q, sb_q;

	// shared units
	logic [127:0] div_num, sq_val;
	logic [63:0]  div_den, mul_a, mul_b;
	logic         div_go, sq_go, mul_go;
	logic [63:0]  quo, root;
	logic [127:0] prod;
	logic         div_done, sq_done, mul_done;

	logic [63:0]  axy, mag_slope, mag_xm, ssr_c, pmag;
	logic [lrs_pkg::ACC_W-1:0] mag_accx, mag_accy;
	logic signed [65:0] a_w;
	lrs_pkg::status_t stat_c;

	// 32-bit negation of the most negative value gives its magnitude 2^31
	assign full      = count_q == FULL_CNT;
	assign axy       = sxy_q[63] ? 64'(-sxy_q) : 64'(sxy_q);
	assign mag_slope = {32'd0, (slope_q[31] ? -slope_q : slope_q)};
	assign mag_xm    = {32'd0, (xm_q[31] ? -xm_q : xm_q)};
	assign mag_accx  = accx_q[lrs_pkg::ACC_W-1] ? -accx_q : accx_q;
	assign mag_accy  = accy_q[lrs_pkg::ACC_W-1] ? -accy_q : accy_q;

	// load phase
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			ovf_q   <= 1'b0;
			accx_q  <= '0;
			accy_q  <= '0;
		end else if (cmd.clear_set) begin
			count_q <= '0;
			ovf_q   <= 1'b0;
			accx_q  <= '0;
			accy_q  <= '0;
		end else if (cmd.accept) begin
			if (full) begin
				ovf_q <= 1'b1;
			end else begin
				count_q <= count_q + lrs_pkg::CNT_W'(1);
				accx_q  <= accx_q + lrs_pkg::ACC_W'(x_value);
				accy_q  <= accy_q + lrs_pkg::ACC_W'(y_value);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept && !full) begin
			xs_mem[count_q[lrs_pkg::ADDR_W-1:0]] <= x_value;
			ys_mem[count_q[lrs_pkg::ADDR_W-1:0]] <= y_value;
		end
		x_s1 <= xs_mem[idx_q[lrs_pkg::ADDR_W-1:0]];
		y_s1 <= ys_mem[idx_q[lrs_pkg::ADDR_W-1:0]];
	end

	// centered sums, read / deviation / product / accumulate
	assign issue = pass_act_q && (idx_q < count_q);
	assign dx    = $signed({x_s1[31], x_s1}) - $signed({xm_q[31], xm_q});
	assign dy    = $signed({y_s1[31], y_s1}) - $signed({ym_q[31], ym_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pass_act_q  <= 1'b0;
			pass_done_q <= 1'b0;
			idx_q       <= '0;
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
		end else begin
			pass_done_q <= 1'b0;
			v_s1        <= issue;
			v_s2        <= v_s1;
			v_s3        <= v_s2;
			if (cmd.start && cmd.step == lrs_pkg::S_PASS) begin
				pass_act_q <= 1'b1;
				idx_q      <= '0;
			end else if (issue) begin
				idx_q <= idx_q + lrs_pkg::CNT_W'(1);
			end else if (pass_act_q && !v_s1 && !v_s2 && !v_s3) begin
				pass_act_q  <= 1'b0;
				pass_done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		adx_s2 <= dx[32] ? 32'(-dx) : dx[31:0];
		ady_s2 <= dy[32] ? 32'(-dy) : dy[31:0];
		neg_s2 <= dx[32] ^ dy[32];
		pxx_s3 <= adx_s2 * adx_s2;
		pyy_s3 <= ady_s2 * ady_s2;
		pxy_s3 <= adx_s2 * ady_s2;
		neg_s3 <= neg_s2;
		if (cmd.clear_sums) begin
			sxx_q <= '0;
			syy_q <= '0;
			sxy_q <= '0;
		end else if (v_s3) begin
			sxx_q <= sxx_q + (pxx_s3 >> lrs_pkg::FRAC_BITS);
			syy_q <= syy_q + (pyy_s3 >> lrs_pkg::FRAC_BITS);
			sxy_q <= neg_s3 ? sxy_q - $signed(pxy_s3 >> lrs_pkg::FRAC_BITS)
			                : sxy_q + $signed(pxy_s3 >> lrs_pkg::FRAC_BITS);
		end
	end

	// operand selection for the shared units
	always_comb begin
		div_num = '0;
		div_den = '0;
		sq_val  = '0;
		mul_a   = '0;
		mul_b   = '0;
		div_go  = 1'b0;
		sq_go   = 1'b0;
		mul_go  = 1'b0;
		case (cmd.step)
			lrs_pkg::S_MEAN_X: begin
				div_go  = cmd.start;
				div_num = 128'(mag_accx);
				div_den = 64'(count_q);
			end
			lrs_pkg::S_MEAN_Y: begin
				div_go  = cmd.start;
				div_num = 128'(mag_accy);
				div_den = 64'(count_q);
			end
			lrs_pkg::S_SLOPE: begin
				div_go  = cmd.start;
				div_num = 128'(axy) << lrs_pkg::FRAC_BITS;
				div_den = sxx_q;
			end
			lrs_pkg::S_PROD: begin
				mul_go = cmd.start;
				mul_a  = mag_slope;
				mul_b  = mag_xm;
			end
			lrs_pkg::S_SSR_MUL: begin
				mul_go = cmd.start;
				mul_a  = axy;
				mul_b  = axy;
			end
			lrs_pkg::S_SSR_DIV: begin
				div_go  = cmd.start;
				div_num = wide_q;
				div_den = sxx_q;
			end
			lrs_pkg::S_R2: begin
				div_go  = cmd.start;
				div_num = 128'(ssr_q) << lrs_pkg::FRAC_BITS;
				div_den = syy_q;
			end
			lrs_pkg::S_RHO: begin
				sq_go  = cmd.start;
				sq_val = 128'(r2_q) << lrs_pkg::FRAC_BITS;
			end
			lrs_pkg::S_QV: begin
				div_go  = cmd.start;
				div_num = 128'(sse_q);
				div_den = 64'(count_q - 2'd2);
			end
			lrs_pkg::S_SE: begin
				sq_go  = cmd.start;
				sq_val = 128'(q_q) << lrs_pkg::FRAC_BITS;
			end
			lrs_pkg::S_SBQ: begin
				div_go  = cmd.start;
				div_num = 128'(q_q) << (2 * lrs_pkg::FRAC_BITS);
				div_den = sxx_q;
			end
			lrs_pkg::S_SB: begin
				sq_go  = cmd.start;
				sq_val = 128'(sbq_q);
			end
			lrs_pkg::S_TV: begin
				div_go  = cmd.start;
				div_num = 128'(mag_slope) << lrs_pkg::FRAC_BITS;
				div_den = 64'(sb_q);
			end
			default: begin
			end
		endcase
	end

	lrs_div u_div (
		.clk(clk), .arst_n(arst_n), .start(div_go), .num(div_num), .den(div_den),
		.quo(quo), .done(div_done)
	);

	lrs_sqrt u_sqrt (
		.clk(clk), .arst_n(arst_n), .start(sq_go), .val(sq_val), .root(root),
		.done(sq_done)
	);

	lrs_mul u_mul (
		.clk(clk), .arst_n(arst_n), .start(mul_go), .a(mul_a), .b(mul_b), .prod(prod),
		.done(mul_done)
	);

	// intercept: ym - slope * xm
	assign pmag  = prod[63:0] >> lrs_pkg::FRAC_BITS;
	assign a_w   = $signed({{34{ym_q[31]}}, ym_q}) +
		(((slope_q[31]) != (xm_q[31])) ? $signed({2'b00, pmag}) : -$signed({2'b00, pmag}));
	assign ssr_c = (quo > syy_q) ? syy_q : quo;

	// latch each unit result on its done pulse
	always_ff @(posedge clk) begin
		if (div_done || sq_done || mul_done) begin
			case (cmd.step)
				lrs_pkg::S_MEAN_X: xm_q <= accx_q[lrs_pkg::ACC_W-1] ? -quo[31:0] : quo[31:0];
				lrs_pkg::S_MEAN_Y: ym_q <= accy_q[lrs_pkg::ACC_W-1] ? -quo[31:0] : quo[31:0];
				lrs_pkg::S_SLOPE:  slope_q <= lrs_pkg::sat32(sxy_q[63], quo);
				lrs_pkg::S_PROD: begin
					if (a_w > 66'sd2147483647) icpt_q <= 32'sh7FFF_FFFF;
					else if (a_w < -66'sd2147483648) icpt_q <= 32'sh8000_0000;
					else icpt_q <= a_w[31:0];
				end
				lrs_pkg::S_SSR_MUL: wide_q <= prod;
				lrs_pkg::S_SSR_DIV: begin
					ssr_q <= ssr_c;
					sse_q <= syy_q - ssr_c;
				end
				lrs_pkg::S_R2:  r2_q <= (quo > ONE_Q) ? ONE_Q[lrs_pkg::R2_W-1:0]
				                                      : quo[lrs_pkg::R2_W-1:0];
				lrs_pkg::S_RHO: rho_q <= root[lrs_pkg::R2_W-1:0];
				lrs_pkg::S_QV:  q_q <= quo;
				lrs_pkg::S_SE:  se_q <= (root > POS_MAX) ? POS_MAX[30:0] : root[30:0];
				lrs_pkg::S_SBQ: sbq_q <= quo;
				lrs_pkg::S_SB:  sb_q <= (root > POS_MAX) ? POS_MAX[30:0] : root[30:0];
				lrs_pkg::S_TV: begin
					if (sb_q == '0) begin
						if (slope_q == '0) t_q <= '0;
						else t_q <= slope_q[31] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
					end else begin
						t_q <= lrs_pkg::sat32(slope_q[31], quo);
					end
				end
				default: begin
				end
			endcase
		end
	end

	// result register
	always_comb begin
		if (ovf_q) stat_c = lrs_pkg::STAT_OVF;
		else if (count_q < lrs_pkg::CNT_W'(3)) stat_c = lrs_pkg::STAT_FEW;
		else if (sxx_q == '0) stat_c = lrs_pkg::STAT_NO_X;
		else if (syy_q == '0) stat_c = lrs_pkg::STAT_NO_Y;
		else stat_c = lrs_pkg::STAT_OK;
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			status <= stat_c;
			if (stat_c == lrs_pkg::STAT_OK) begin
				intercept       <= icpt_q;
				slope           <= slope_q;
				x_mean          <= xm_q;
				y_mean          <= ym_q;
				r_squared       <= r2_q;
				correlation     <= slope_q[31] ? -$signed({1'b0, rho_q}) : $signed({1'b0, rho_q});
				std_error       <= se_q;
				slope_std_error <= sb_q;
				t_value         <= t_q;
			end else begin
				intercept       <= '0;
				slope           <= '0;
				x_mean          <= '0;
				y_mean          <= '0;
				r_squared       <= '0;
				correlation     <= '0;
				std_error       <= '0;
				slope_std_error <= '0;
				t_value         <= '0;
			end
		end
	end

	assign sts.unit_done  = div_done | sq_done | mul_done;
	assign sts.pass_done  = pass_done_q;
	assign sts.pre_err    = ovf_q || (count_q < lrs_pkg::CNT_W'(3));
	assign sts.spread_err = (sxx_q == '0) || (syy_q == '0);

endmodule

// ----- design/lrs_ctrl.sv -----
module lrs_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	input  logic          in_last,
	output logic          in_ready,
	output logic          out_valid,
	input  logic          out_ready,
	input  lrs_pkg::sts_t sts,
	output lrs_pkg::cmd_t cmd
);

	lrs_pkg::step_t state_q, state_d;
	logic           busy_q, busy_d;
	logic           ovalid_q, ovalid_d;

	function automatic lrs_pkg::step_t next_step(input lrs_pkg::step_t s);
		lrs_pkg::step_t n;
		unique case (s)
			lrs_pkg::S_MEAN_X:  n = lrs_pkg::S_MEAN_Y;
			lrs_pkg::S_MEAN_Y:  n = lrs_pkg::S_PASS;
			lrs_pkg::S_SLOPE:   n = lrs_pkg::S_PROD;
			lrs_pkg::S_PROD:    n = lrs_pkg::S_SSR_MUL;
			lrs_pkg::S_SSR_MUL: n = lrs_pkg::S_SSR_DIV;
			lrs_pkg::S_SSR_DIV: n = lrs_pkg::S_R2;
			lrs_pkg::S_R2:      n = lrs_pkg::S_RHO;
			lrs_pkg::S_RHO:     n = lrs_pkg::S_QV;
			lrs_pkg::S_QV:      n = lrs_pkg::S_SE;
			lrs_pkg::S_SE:      n = lrs_pkg::S_SBQ;
			lrs_pkg::S_SBQ:     n = lrs_pkg::S_SB;
			lrs_pkg::S_SB:      n = lrs_pkg::S_TV;
			default:            n = lrs_pkg::S_DONE;
		endcase
		return n;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= lrs_pkg::S_LOAD;
			busy_q   <= 1'b0;
			ovalid_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			busy_q   <= busy_d;
			ovalid_q <= ovalid_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		busy_d   = busy_q;
		ovalid_d = ovalid_q;
		cmd      = '0;
		cmd.step = state_q;
		in_ready = (state_q == lrs_pkg::S_LOAD);
		if (ovalid_q && out_ready) ovalid_d = 1'b0;
		unique case (state_q)
			lrs_pkg::S_LOAD: begin
				cmd.accept = in_valid;
				if (in_valid && in_last) state_d = lrs_pkg::S_CHECK;
			end
			lrs_pkg::S_CHECK: begin
				cmd.clear_sums = 1'b1;
				state_d = sts.pre_err ? lrs_pkg::S_DONE : lrs_pkg::S_MEAN_X;
			end
			lrs_pkg::S_PASS: begin
				if (!busy_q) begin
					cmd.start = 1'b1;
					busy_d    = 1'b1;
				end else if (sts.pass_done) begin
					busy_d  = 1'b0;
					state_d = sts.spread_err ? lrs_pkg::S_DONE : lrs_pkg::S_SLOPE;
				end
			end
			lrs_pkg::S_DONE: begin
				if (!ovalid_q || out_ready) begin
					cmd.load_out  = 1'b1;
					cmd.clear_set = 1'b1;
					ovalid_d      = 1'b1;
					state_d       = lrs_pkg::S_LOAD;
				end
			end
			default: begin
				if (!busy_q) begin
					cmd.start = 1'b1;
					busy_d    = 1'b1;
				end else if (sts.unit_done) begin
					busy_d  = 1'b0;
					state_d = next_step(state_q);
				end
			end
		endcase
	end

	assign out_valid = ovalid_q;

	a_done_when_busy: assert property (@(posedge clk) disable iff (!arst_n)
		sts.unit_done |-> busy_q)
		else $error("unit finished with no operation in flight");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> (!ovalid_q || out_ready))
		else $error("result register overwritten before it was taken");

	a_clear_to_load: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.clear_set |=> (state_q == lrs_pkg::S_LOAD && out_valid))
		else $error("set cleared without returning to load with a result");

	a_no_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.start |-> !busy_q)
		else $error("operation started while another is running");

endmodule

// ----- design/linear_regression_stats_core.sv -----
// least-squares line fit over a set of signed Q16.16 (x, y) pairs
//
// samples: one request per pair, valid/ready; last_point closes the set.
//   during the load phase a pair is taken every cycle; the pair store holds
//   up to 128 pairs, extra pairs are dropped and reported as store overflow
// results: one request per closed set carrying slope, intercept, means,
//   r squared, signed correlation, standard errors, t value and status
// the fit runs two mean divisions, a second pass over the store at one pair a
//   cycle, six more divisions on the same shared restoring divider, three
//   square roots and two multiplies, one after another
// error sets (overflow, under three pairs, no x or y spread) skip the rest
//   of the fit and report zeros with the status code
// the result sits in an output register; while it waits the block already
//   loads the next set. if a second set finishes before the first result is
//   taken, the controller holds in its final step and stops taking pairs
// reset clears the pair count, the sums, the overflow flag and the output
//   valid; the store itself is not cleared, only written entries are read
module linear_regression_stats_core (
	input logic      clk,
	input logic      arst_n,
	lrs_in_if.sink   samples,
	lrs_out_if.source results
);

	lrs_pkg::cmd_t cmd;
	lrs_pkg::sts_t sts;

	// sequencer: load, means, second pass, fit steps, result handoff
	lrs_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(samples.valid),
		.in_last(samples.last_point),
		.in_ready(samples.ready),
		.out_valid(results.valid),
		.out_ready(results.ready),
		.sts(sts),
		.cmd(cmd)
	);

	// store, sums, shared divide / root / multiply units and result register
	lrs_dp u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd),
		.sts(sts),
		.x_value(samples.x_value),
		.y_value(samples.y_value),
		.intercept(results.intercept),
		.slope(results.slope),
		.x_mean(results.x_mean),
		.y_mean(results.y_mean),
		.r_squared(results.r_squared),
		.correlation(results.correlation),
		.std_error(results.std_error),
		.slope_std_error(results.slope_std_error),
		.t_value(results.t_value),
		.status(results.status)
	);

endmodule

// ----- tb/sv/linear_regression_stats_core_test.sv -----
module linear_regression_stats_core_test;

	localparam longint POS_LIM = 64'sd2147483647;
	localparam longint NEG_LIM = -64'sd2147483648;
	localparam int STALL_LIMIT = 8000;
	localparam int DRAIN_CYCLES = 1600;

	// one fit result, at the widths of the result channel
	typedef struct packed {
		logic [31:0] intercept;
		logic [31:0] slope;
		logic [31:0] x_mean;
		logic [31:0] y_mean;
		logic [16:0] r_squared;
		logic [17:0] correlation;
		logic [30:0] std_error;
		logic [30:0] slope_std_error;
		logic [31:0] t_value;
		logic [2:0]  status;
	} fit_t;

	// tracks the pair set as the block sees it and predicts each fit
	class fit_ledger;
		longint xs[$];
		longint ys[$];
		bit     dropped;
		longint sum_x, sum_y;
		fit_t   pending_fits[$];
		int     errors;

		function bit [63:0] mag(longint v);
			return v < 0 ? 64'(-v) : 64'(v);
		endfunction

		function longint clamp32(bit neg, bit [63:0] m);
			if (neg) return m > 64'd2147483648 ? NEG_LIM : -longint'(m);
			return m > 64'(POS_LIM) ? POS_LIM : longint'(m);
		endfunction

		// floor division, all ones when the divisor is zero or the quotient needs more than 64 bits
		function bit [63:0] div_sat(bit [127:0] num, bit [63:0] den);
			bit [127:0] q;
			if (den == 0) return '1;
			q = num / {64'd0, den};
			return q[127:64] != 0 ? '1 : q[63:0];
		endfunction

		// floor square root, two bits per step
		function bit [63:0] isqrt(bit [127:0] v);
			bit [129:0] rem, trial;
			bit [63:0]  root;
			rem = 0;
			root = 0;
			for (int j = 63; j >= 0; j--) begin
				rem = (rem << 2) | 130'(v[2*j +: 2]);
				trial = {64'd0, root, 2'b01};
				if (rem >= trial) begin
					rem = rem - trial;
					root = {root[62:0], 1'b1};
				end else begin
					root = {root[62:0], 1'b0};
				end
			end
			return root;
		endfunction

		function fit_t fit();
			fit_t   f;
			longint n, xm, ym, dx, dy, sxy, term, s, slope, p, a, t;
			bit [63:0] sxx, syy, adx, ady, tmp, axy, bmag, ssr, sse, r2, rmag;
			bit [63:0] q, se, sb, sbq;
			bit [64:0] s65;
			bit [127:0] wa;
			f = '0;
			n = xs.size();
			if (dropped) f.status = lrs_pkg::STAT_OVF;
			else if (n < 3) f.status = lrs_pkg::STAT_FEW;
			if (f.status != lrs_pkg::STAT_OK) return f;
			xm = sum_x / n;
			ym = sum_y / n;
			sxx = 0;
			syy = 0;
			sxy = 0;
			// centered second pass, each product truncated toward zero
			for (int i = 0; i < n; i++) begin
				dx = xs[i] - xm;
				dy = ys[i] - ym;
				adx = mag(dx);
				ady = mag(dy);
				tmp = adx * adx;
				s65 = {1'b0, sxx} + {1'b0, tmp >> lrs_pkg::FRAC_BITS};
				sxx = s65[64] ? '1 : s65[63:0];
				tmp = ady * ady;
				s65 = {1'b0, syy} + {1'b0, tmp >> lrs_pkg::FRAC_BITS};
				syy = s65[64] ? '1 : s65[63:0];
				tmp = (adx * ady) >> lrs_pkg::FRAC_BITS;
				term = ((dx < 0) != (dy < 0)) ? -longint'(tmp) : longint'(tmp);
				s = sxy + term;
				if (term > 0 && s < sxy) s = 64'sh7FFF_FFFF_FFFF_FFFF;
				if (term < 0 && s > sxy) s = 64'sh8000_0000_0000_0000;
				sxy = s;
			end
			if (sxx == 0) begin
				f.status = lrs_pkg::STAT_NO_X;
				return f;
			end
			if (syy == 0) begin
				f.status = lrs_pkg::STAT_NO_Y;
				return f;
			end
			axy = mag(sxy);
			bmag = div_sat(128'(axy) << lrs_pkg::FRAC_BITS, sxx);
			slope = clamp32(sxy < 0, bmag);
			p = longint'((mag(slope) * mag(xm)) >> lrs_pkg::FRAC_BITS);
			if ((slope < 0) != (xm < 0)) p = -p;
			a = ym - p;
			a = a > POS_LIM ? POS_LIM : (a < NEG_LIM ? NEG_LIM : a);
			wa = 128'(axy);
			ssr = div_sat(wa * wa, sxx);
			if (ssr > syy) ssr = syy;
			sse = syy - ssr;
			r2 = div_sat(128'(ssr) << lrs_pkg::FRAC_BITS, syy);
			if (r2 > (64'd1 << lrs_pkg::FRAC_BITS)) r2 = 64'd1 << lrs_pkg::FRAC_BITS;
			rmag = isqrt(128'(r2) << lrs_pkg::FRAC_BITS);
			q = sse / 64'(n - 2);
			se = isqrt(128'(q) << lrs_pkg::FRAC_BITS);
			if (se > 64'(POS_LIM)) se = 64'(POS_LIM);
			sbq = div_sat(128'(q) << (2 * lrs_pkg::FRAC_BITS), sxx);
			sb = isqrt(128'(sbq));
			if (sb > 64'(POS_LIM)) sb = 64'(POS_LIM);
			// zero slope error: t pins to the sign of the slope
			if (sb == 0) t = slope > 0 ? POS_LIM : (slope < 0 ? NEG_LIM : 0);
			else t = clamp32(slope < 0,
				div_sat(128'(mag(slope)) << lrs_pkg::FRAC_BITS, sb));
			f.intercept = a[31:0];
			f.slope = slope[31:0];
			f.x_mean = xm[31:0];
			f.y_mean = ym[31:0];
			f.r_squared = r2[16:0];
			f.correlation = slope < 0 ? 18'(-longint'(rmag)) : rmag[17:0];
			f.std_error = se[30:0];
			f.slope_std_error = sb[30:0];
			f.t_value = t[31:0];
			return f;
		endfunction

		function void note_request(logic [31:0] x, logic [31:0] y, logic last);
			if (xs.size() < lrs_pkg::MAX_POINTS) begin
				xs.push_back(longint'($signed(x)));
				ys.push_back(longint'($signed(y)));
				sum_x += longint'($signed(x));
				sum_y += longint'($signed(y));
			end else begin
				dropped = 1;
			end
			if (last) begin
				pending_fits.push_back(fit());
				xs.delete();
				ys.delete();
				dropped = 0;
				sum_x = 0;
				sum_y = 0;
			end
		endfunction

		function void field(string name, logic [31:0] e, logic [31:0] g);
			if (e !== g) begin
				errors++;
				$display("%0t: %s expected %h got %h", $time, name, e, g);
			end
		endfunction

		function void check(fit_t got);
			fit_t e;
			if (pending_fits.size() == 0) begin
				errors++;
				$display("%0t: unexpected result, status got %0d", $time, got.status);
				return;
			end
			e = pending_fits.pop_front();
			field("intercept", e.intercept, got.intercept);
			field("slope", e.slope, got.slope);
			field("x_mean", e.x_mean, got.x_mean);
			field("y_mean", e.y_mean, got.y_mean);
			field("r_squared", 32'(e.r_squared), 32'(got.r_squared));
			field("correlation", 32'(e.correlation), 32'(got.correlation));
			field("std_error", 32'(e.std_error), 32'(got.std_error));
			field("slope_std_error", 32'(e.slope_std_error), 32'(got.slope_std_error));
			field("t_value", e.t_value, got.t_value);
			field("status", 32'(e.status), 32'(got.status));
		endfunction
	endclass

	logic clk;
	logic arst_n;
	lrs_in_if  sample_bus();
	lrs_out_if result_bus();

	linear_regression_stats_core DUT (
		.clk(clk),
		.arst_n(arst_n),
		.samples(sample_bus),
		.results(result_bus)
	);

	fit_ledger ledger = new();
	bit calm;        // stretch with no idling on either side
	int pairs_sent;
	int idle_cycles;

	always #4 clk = ~clk;

	// mostly short gaps, a few long ones, none during a calm stretch
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (calm || r < 60) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// present one pair and hold it until the block takes the request
	task automatic send_pair(logic [31:0] x, logic [31:0] y, logic last);
		int g;
		g = pick_gap();
		if (g > 0) begin
			sample_bus.valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
		sample_bus.valid <= 1'b1;
		sample_bus.x_value <= x;
		sample_bus.y_value <= y;
		sample_bus.last_point <= last;
		do @(posedge clk); while (!sample_bus.ready);
		ledger.note_request(x, y, last);
		pairs_sent++;
	endtask

	// one set of n pairs; shape picks how the values relate
	task automatic send_set(int n, int shape);
		int slope_k, x, y, x_fix;
		slope_k = $urandom_range(0, 8) - 4;
		x_fix = $urandom;
		calm = ($urandom_range(0, 4) == 0);
		for (int i = 0; i < n; i++) begin
			x = int'($urandom_range(0, 1 << 22)) - (1 << 21);
			y = slope_k * x + int'($urandom_range(0, 1 << 18)) - (1 << 17);
			case (shape)
				0: begin
					x = $urandom;
					y = $urandom;
				end
				2: x = x_fix;
				3: y = x_fix;
				default: ;
			endcase
			send_pair(x, y, i == n - 1);
		end
	endtask

	task automatic wait_drained();
		sample_bus.valid <= 1'b0;
		while (ledger.pending_fits.size() != 0) @(posedge clk);
	endtask

	// result side stalls
	initial begin
		result_bus.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			int g;
			g = pick_gap();
			if (g > 0) begin
				result_bus.ready <= 1'b0;
				repeat (g) @(posedge clk);
			end
			result_bus.ready <= 1'b1;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
	end

	always @(posedge clk) begin
		if (arst_n && result_bus.valid && result_bus.ready)
			ledger.check({result_bus.intercept, result_bus.slope, result_bus.x_mean,
				result_bus.y_mean, result_bus.r_squared, result_bus.correlation,
				result_bus.std_error, result_bus.slope_std_error, result_bus.t_value,
				result_bus.status});
	end

	// watchdog on cycles in which neither channel moves a request
	always @(posedge clk) begin
		if ((sample_bus.valid && sample_bus.ready) || (result_bus.valid && result_bus.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > STALL_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		idle_cycles = 0;
		sample_bus.valid = 1'b0;
		sample_bus.x_value = '0;
		sample_bus.y_value = '0;
		sample_bus.last_point = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// under three pairs
		send_pair(32'h7FFF_FFFF, 32'h8000_0000, 1'b1);
		send_pair(32'h0001_0000, 32'h0002_0000, 1'b0);
		send_pair(32'h0003_0000, 32'hFFFF_0000, 1'b1);
		// no x spread
		send_pair(32'h0005_0000, 32'h0000_0001, 1'b0);
		send_pair(32'h0005_0000, 32'h0000_0002, 1'b0);
		send_pair(32'h0005_0000, 32'h0000_0003, 1'b1);
		// x spread lost below one lsb of the centered square
		send_pair(32'h0000_0000, 32'h0001_0000, 1'b0);
		send_pair(32'h0000_0001, 32'h0003_0000, 1'b0);
		send_pair(32'h0000_0002, 32'h0000_0000, 1'b1);
		// no y spread
		send_pair(32'h0000_0000, 32'hFFF9_0000, 1'b0);
		send_pair(32'h0001_0000, 32'hFFF9_0000, 1'b0);
		send_pair(32'h0002_0000, 32'hFFF9_0000, 1'b1);
		// exact line, zero slope error so t saturates
		send_pair(32'h0000_0000, 32'h0001_0000, 1'b0);
		send_pair(32'h0001_0000, 32'h0003_0000, 1'b0);
		send_pair(32'h0002_0000, 32'h0005_0000, 1'b0);
		send_pair(32'h0003_0000, 32'h0007_0000, 1'b1);
		// zero slope
		send_pair(32'h0000_0000, 32'h0000_0000, 1'b0);
		send_pair(32'h0001_0000, 32'h0001_0000, 1'b0);
		send_pair(32'h0002_0000, 32'h0000_0000, 1'b1);
		// field extremes, saturating sums and results
		send_pair(32'h8000_0000, 32'h7FFF_FFFF, 1'b0);
		send_pair(32'h7FFF_FFFF, 32'h8000_0000, 1'b0);
		send_pair(32'h0000_0000, 32'hFFFF_FFFF, 1'b0);
		send_pair(32'hFFFF_FFFF, 32'h0000_0000, 1'b1);

		// sender holds off until every fit so far has come back
		wait_drained();
		@(posedge clk);

		send_set(lrs_pkg::MAX_POINTS, 1);
		send_set(lrs_pkg::MAX_POINTS + 2, 1);   // store overflow
		while (pairs_sent < 450) begin
			int r;
			r = $urandom_range(0, 99);
			if (r < 8) send_set($urandom_range(1, 2), 1);
			else if (r < 14) send_set($urandom_range(3, 8), 2);
			else if (r < 20) send_set($urandom_range(3, 8), 3);
			else if (r < 32) send_set($urandom_range(3, 10), 0);
			else if (r < 40) send_set($urandom_range(11, 40), 1);
			else send_set($urandom_range(3, 10), 1);
		end

		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (ledger.errors == 0 && ledger.pending_fits.size() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

// ----- files.f -----
design/lrs_pkg.sv
design/lrs_if.sv
design/lrs_div.sv
design/lrs_sqrt.sv
design/lrs_mul.sv
design/lrs_dp.sv
design/lrs_ctrl.sv
design/linear_regression_stats_core.sv
tb/sv/linear_regression_stats_core_test.sv
